// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the top-k heap tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk, off during reset.
`define TKMH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TKMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TKMH_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TKMH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tkmh_pkg.sv =====
// Shared types and codes for the top-k min-heap tracker.
package tkmh_pkg;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
    } entry_t;

    // Write-back from a level to the level above it
    typedef struct packed {
        logic   we;
        entry_t ent;
    } up_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_FETCH,
        C_HOLD
    } cell_state_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_READ,
        S_SIFT,
        S_DONE
    } top_state_t;

    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

endpackage

// ===== rtl/top_k_min_heap_tracker.sv =====
// Top level of the top-k min-heap tracker: root slot, control and the chain of levels.
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall   | func, cand_key, cand_count, read_index
//  out     | out_valid / out_stall | accepted, evicted_key, evicted_count, min_count,
//          |                       | entry_key, entry_count
//
// An accepted offer sifts down one level a cycle: the level RAM read is issued as the
// entry is handed on, and the compare and move follow in the next cycle. At 128 slots
// there are 7 levels below the root. A result is loaded in S_DONE; a read passes S_READ
// first, while a rejected offer or a read of slot 0 goes straight from idle to S_DONE.
// After reset a clearing pass writes zeros over every row of each level RAM, stepping
// through the rows of the deepest one; in_stall stays high throughout.
// One item is worked at a time; the next is taken while a result waits on out_stall.
`include "assert_macros.svh"

module top_k_min_heap_tracker #(
    parameter int HEAP_SIZE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] cand_key,
    input  logic [31:0] cand_count,
    input  logic [6:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [31:0] evicted_key,
    output logic [31:0] evicted_count,
    output logic [31:0] min_count,
    output logic [31:0] entry_key,
    output logic [31:0] entry_count
);

    import tkmh_pkg::*;

    localparam int LEVELS   = $clog2(HEAP_SIZE + 1);
    localparam int OFFW     = LEVELS;
    localparam int IW       = LEVELS + 1;
    localparam int CLR_ROWS = 1 << (LEVELS - 2);
    localparam int CW       = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

    top_state_t    state_reg, state_next;
    entry_t        root_reg;
    logic [CW-1:0] clr_reg;
    logic          pacc_reg;
    entry_t        pev_reg;
    entry_t        pent_reg;
    logic          out_valid_reg;
    logic          acc_out_reg;
    entry_t        ev_out_reg;
    logic [31:0]   min_out_reg;
    entry_t        ent_out_reg;

    logic          in_go;
    logic          offer_win;
    logic          idx_ok;
    logic          start;
    logic          rd_en;
    logic          out_load;
    logic [7:0]    rd_pos;
    entry_t        cand_ent;
    entry_t        rd_or;

    logic            tok_v   [LEVELS+1];
    logic [OFFW-1:0] tok_off [LEVELS+1];
    entry_t          tok_e   [LEVELS+1];
    up_t             up      [LEVELS+1];
    entry_t          rd_ents [LEVELS];
    logic [LEVELS-1:0] fin_vec;

    assign in_stall  = state_reg != S_IDLE;
    assign in_go     = in_valid && !in_stall;
    assign offer_win = cand_count > root_reg.count;
    assign idx_ok    = 32'(read_index) < 32'(HEAP_SIZE);
    assign rd_pos    = {1'b0, read_index} + 8'd1;
    assign cand_ent  = '{key: cand_key, count: cand_count};
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign tok_v[0]   = 1'b0;
    assign tok_off[0] = '0;
    assign tok_e[0]   = '0;
    assign tok_v[1]   = start;
    assign tok_off[1] = '0;
    assign tok_e[1]   = cand_ent;
    assign up[0]      = '0;
    assign up[LEVELS] = '0;
    assign rd_ents[0] = '0;
    assign fin_vec[0] = 1'b0;

    for (genvar l = 1; l < LEVELS; l++)
    begin : g_lvl
        tkmh_cell #(
            .LVL       (l),
            .HEAP_SIZE (HEAP_SIZE),
            .OFFW      (OFFW),
            .CW        (CW),
            .IW        (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clr_en    (state_reg == S_CLR),
            .clr_row   (clr_reg),
            .tok_valid (tok_v[l]),
            .tok_off   (tok_off[l]),
            .tok_ent   (tok_e[l]),
            .nxt_valid (tok_v[l+1]),
            .nxt_off   (tok_off[l+1]),
            .nxt_ent   (tok_e[l+1]),
            .up_in     (up[l+1]),
            .up_out    (up[l]),
            .fin       (fin_vec[l]),
            .rd_en     (rd_en),
            .rd_pos    (rd_pos),
            .rd_ent    (rd_ents[l])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            rd_or = rd_or | rd_ents[l];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_reg == CW'(CLR_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_go)
                begin
                    if (func == FUNC_OFFER && offer_win)
                    begin
                        state_next = S_SIFT;
                    end
                    else if (func == FUNC_READ && idx_ok && read_index != 7'd0)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SIFT:
            begin
                if (|fin_vec)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        start = 1'b0;
        rd_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                start = in_go && func == FUNC_OFFER && offer_win;
                rd_en = in_go && func == FUNC_READ && idx_ok && read_index != 7'd0;
            end
            default:
            begin
                start = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            // Level one writes the root back during a sift
            if (up[1].we)
            begin
                root_reg <= up[1].ent;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            pacc_reg <= (func == FUNC_OFFER) && offer_win;
            pev_reg  <= (func == FUNC_OFFER && offer_win) ? root_reg : '0;
            pent_reg <= (func == FUNC_READ && read_index == 7'd0) ? root_reg : '0;
        end
        if (state_reg == S_READ)
        begin
            pent_reg <= rd_or;
        end
        if (out_load)
        begin
            acc_out_reg <= pacc_reg;
            ev_out_reg  <= pev_reg;
            min_out_reg <= root_reg.count;
            ent_out_reg <= pent_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_out_reg;
    assign evicted_key   = ev_out_reg.key;
    assign evicted_count = ev_out_reg.count;
    assign min_count     = min_out_reg;
    assign entry_key     = ent_out_reg.key;
    assign entry_count   = ent_out_reg.count;

    `TKMH_ASSERT_IMPLY(a_fin_only_in_sift, |fin_vec, state_reg == S_SIFT, "sift end outside sift")
    `TKMH_ASSERT_IMPLY(a_evict_not_above_min, out_valid && accepted, evicted_count <= min_count, "evicted count above new minimum")
    `TKMH_ASSERT_NEXT(a_read_one_cycle, state_reg == S_READ, state_reg == S_DONE, "read did not finish in one cycle")

endmodule

// ===== rtl/tkmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tkmh_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tkmh_cell.sv =====
// One heap level: pairs of sibling slots in a RAM, one sift step per visit.
module tkmh_cell #(
    parameter int LVL       = 1,
    parameter int HEAP_SIZE = 128,
    parameter int OFFW      = 8,
    parameter int CW        = 6,
    parameter int IW        = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr_en,
    input  logic [CW-1:0]     clr_row,
    input  logic              tok_valid,
    input  logic [OFFW-1:0]   tok_off,
    input  tkmh_pkg::entry_t  tok_ent,
    output logic              nxt_valid,
    output logic [OFFW-1:0]   nxt_off,
    output tkmh_pkg::entry_t  nxt_ent,
    input  tkmh_pkg::up_t     up_in,
    output tkmh_pkg::up_t     up_out,
    output logic              fin,
    input  logic              rd_en,
    input  logic [7:0]        rd_pos,
    output tkmh_pkg::entry_t  rd_ent
);

    import tkmh_pkg::*;

    localparam int ROWS = 1 << (LVL - 1);
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [IW-1:0] BASE      = IW'((1 << LVL) - 1);
    localparam logic [IW-1:0] NEXT_BASE = IW'((1 << (LVL + 1)) - 1);
    localparam logic [IW-1:0] HSZ       = IW'(HEAP_SIZE);

    cell_state_t   state_reg, state_next;
    logic [AW-1:0] row_reg;
    entry_t        ent_reg;
    logic [127:0]  pair_reg;
    logic          half_reg;
    logic          rd_hit_reg;
    logic          rd_half_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [127:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [127:0]  pair_rd;

    entry_t        left_ent, right_ent, child_ent;
    logic          right_ok, pick_r, move, next_ok;
    logic [7:0]    rd_off;
    logic          rd_hit;

    function automatic logic [127:0] put_half(input logic [127:0] pair, input logic half,
                                              input entry_t ent);
        logic [127:0] res;
        res = pair;
        if (half)
        begin
            res[127:64] = ent;
        end
        else
        begin
            res[63:0] = ent;
        end
        return res;
    endfunction

    tkmh_ram #(
        .WIDTH (128),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (pair_rd)
    );

    // Pick the smaller child; right only where it exists and is strictly smaller
    assign left_ent  = pair_rd[63:0];
    assign right_ent = pair_rd[127:64];
    assign right_ok  = (BASE + IW'({row_reg, 1'b1})) < HSZ;
    assign pick_r    = right_ok && (right_ent.count < left_ent.count);
    assign child_ent = pick_r ? right_ent : left_ent;
    assign move      = child_ent.count < ent_reg.count;
    assign next_ok   = (NEXT_BASE + IW'({row_reg, pick_r, 1'b0})) < HSZ;

    assign rd_hit = (rd_pos >> LVL) == 8'd1;
    assign rd_off = rd_pos ^ (8'd1 << LVL);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (tok_valid)
                begin
                    state_next = C_FETCH;
                end
            end
            C_FETCH:
            begin
                if (move && next_ok)
                begin
                    state_next = C_HOLD;
                end
                else
                begin
                    state_next = C_IDLE;
                end
            end
            C_HOLD:
            begin
                if (up_in.we)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = '0;
        ram_raddr = tok_off[AW-1:0];
        nxt_valid = 1'b0;
        nxt_off   = OFFW'({row_reg, pick_r});
        nxt_ent   = ent_reg;
        up_out    = '0;
        fin       = 1'b0;
        if (clr_en && (clr_row <= CW'(ROWS - 1)))
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(clr_row);
        end
        case (state_reg)
            C_IDLE:
            begin
                if (rd_en)
                begin
                    ram_raddr = AW'(rd_off >> 1);
                end
            end
            C_FETCH:
            begin
                if (move)
                begin
                    up_out.we  = 1'b1;
                    up_out.ent = child_ent;
                    if (next_ok)
                    begin
                        nxt_valid = 1'b1;
                    end
                    else
                    begin
                        // No level below: settle the entry here
                        ram_we    = 1'b1;
                        ram_wdata = put_half(pair_rd, pick_r, ent_reg);
                        fin       = 1'b1;
                    end
                end
                else
                begin
                    up_out.we  = 1'b1;
                    up_out.ent = ent_reg;
                    fin        = 1'b1;
                end
            end
            C_HOLD:
            begin
                if (up_in.we)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = put_half(pair_reg, half_reg, up_in.ent);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_hit_reg <= rd_en && rd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_half_reg <= rd_off[0];
        if (state_reg == C_IDLE && tok_valid)
        begin
            row_reg <= tok_off[AW-1:0];
            ent_reg <= tok_ent;
        end
        if (state_reg == C_FETCH)
        begin
            pair_reg <= pair_rd;
            half_reg <= pick_r;
        end
    end

    assign rd_ent = rd_hit_reg ? (rd_half_reg ? right_ent : left_ent) : '0;

endmodule
